FILE: sv/fvtb_pkg.sv
`timescale 1ns / 1ps
// Shared constants, widths and converter handshake structs for the FLV video tag builder.
// No dependencies; the design files refer to this package by scoped names, the testbench by import.
package fvtb_pkg;

  // Field and datapath widths
  localparam int TICK_W    = 40;  // signed frame-tick times
  localparam int RATE_W    = 10;  // frame rate register
  localparam int QUO_W     = 49;  // |ticks| * 1000 + rate/2 and its quotient
  localparam int MS_W      = 50;  // signed millisecond values
  localparam int SIZE_W    = 24;  // payload size
  localparam int TRAILER_W = 25;  // previous-tag-size word
  localparam int HALF_W    = 64;  // one half of the 16-byte tag header
  localparam int CNT_W     = 6;   // divide step counter

  // Register reset and limits
  localparam logic [RATE_W-1:0] RATE_RESET  = 10'd30;
  localparam logic [SIZE_W-1:0] MAX_PAYLOAD = 24'd16777210;

  // Tag header codes
  localparam logic [7:0]           VID_TAG_TYPE     = 8'h09;
  localparam logic [3:0]           CODEC_AVC        = 4'h7;
  localparam logic [3:0]           KEY_FRAME_CODE   = 4'h1;
  localparam logic [3:0]           INTER_FRAME_CODE = 4'h2;
  localparam logic [7:0]           PKT_NALU         = 8'h01;
  localparam logic [7:0]           PKT_END_SEQ      = 8'h02;
  localparam logic [SIZE_W-1:0]    DATA_HDR_LEN     = 24'd5;
  localparam logic [TRAILER_W-1:0] TAG_HDR_LEN      = 25'd16;

  // Request into the tick-to-millisecond converter
  typedef struct packed {
    logic                     start;
    logic signed [TICK_W-1:0] ticks;
    logic [RATE_W-1:0]        rate;
  } conv_req_t;

  // Response from the converter: done pulses for one cycle with ms valid
  typedef struct packed {
    logic                   done;
    logic signed [MS_W-1:0] ms;
  } conv_rsp_t;

endpackage

FILE: sv/fvtb_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for frame descriptors and tag header results.
// Depends on fvtb_pkg for field widths.
interface fvtb_in_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [fvtb_pkg::SIZE_W-1:0]        payload_size;
  logic signed [fvtb_pkg::TICK_W-1:0] present_time;
  logic signed [fvtb_pkg::TICK_W-1:0] decode_time;
  logic                               is_keyframe;

  modport source (output valid, mode, payload_size, present_time, decode_time, is_keyframe,
                  input ready);
  modport sink (input valid, mode, payload_size, present_time, decode_time, is_keyframe,
                output ready);
endinterface

interface fvtb_out_if;
  logic                           valid;
  logic                           ready;
  logic [fvtb_pkg::HALF_W-1:0]    header_first_half;
  logic [fvtb_pkg::HALF_W-1:0]    header_second_half;
  logic [fvtb_pkg::TRAILER_W-1:0] trailer_size;
  logic                           status;

  modport source (output valid, header_first_half, header_second_half, trailer_size, status,
                  input ready);
  modport sink (input valid, header_first_half, header_second_half, trailer_size, status,
                output ready);
endinterface

FILE: sv/fvtb_ms_conv.sv
`timescale 1ns / 1ps
// Tick-to-millisecond converter: sign(t) * ((|t| * 1000 + rate/2) / rate),
// built on one restoring divider that retires one quotient bit per cycle. Uses fvtb_pkg.
module fvtb_ms_conv (
  input  logic                clk,
  input  logic                rst_n,
  input  fvtb_pkg::conv_req_t req,
  output fvtb_pkg::conv_rsp_t rsp
);

  typedef enum logic [5:0] {
    CV_IDLE = 6'b000001,
    CV_ABS  = 6'b000010,
    CV_MUL3 = 6'b000100,
    CV_SUB  = 6'b001000,
    CV_DIV  = 6'b010000,
    CV_SIGN = 6'b100000
  } cv_state_t;

  cv_state_t                          state_r, state_nxt;
  logic                               done_r, done_nxt;
  logic [fvtb_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [fvtb_pkg::TICK_W-1:0] ticks_r, ticks_nxt;
  logic                               neg_r, neg_nxt;
  logic [fvtb_pkg::RATE_W-1:0]        div_r, div_nxt;
  logic [fvtb_pkg::RATE_W-2:0]        half_r, half_nxt;
  logic [fvtb_pkg::TICK_W-1:0]        mag_r, mag_nxt;
  logic [fvtb_pkg::TICK_W+1:0]        mag3_r, mag3_nxt;
  logic [fvtb_pkg::QUO_W-1:0]         quo_r, quo_nxt;
  logic [fvtb_pkg::RATE_W-1:0]        rem_r, rem_nxt;
  logic signed [fvtb_pkg::MS_W-1:0]   ms_r, ms_nxt;

  logic [fvtb_pkg::RATE_W:0]          part;
  logic [fvtb_pkg::RATE_W:0]          part_diff;
  logic                               part_ge;
  logic [fvtb_pkg::MS_W-1:0]          scaled;
  logic [fvtb_pkg::MS_W-1:0]          quo_ext;

  // One restoring divide step: shift in the next dividend bit, subtract if it fits
  assign part      = {rem_r, quo_r[fvtb_pkg::QUO_W-1]};
  assign part_ge   = part >= {1'b0, div_r};
  assign part_diff = part - {1'b0, div_r};

  // |t| * 1000 + rate/2 = (|t| << 10 | rate/2) - 3|t| << 3, since rate/2 < 1024
  assign scaled  = {mag_r, 1'b0, half_r} - {5'd0, mag3_r, 3'd0};
  assign quo_ext = {1'b0, quo_r};

  // Sequence the conversion
  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    ticks_nxt = ticks_r;
    neg_nxt   = neg_r;
    div_nxt   = div_r;
    half_nxt  = half_r;
    mag_nxt   = mag_r;
    mag3_nxt  = mag3_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    ms_nxt    = ms_r;
    case (state_r)
      CV_IDLE: begin
        if (req.start) begin
          ticks_nxt = req.ticks;
          neg_nxt   = req.ticks[fvtb_pkg::TICK_W-1];
          div_nxt   = req.rate;
          half_nxt  = req.rate[fvtb_pkg::RATE_W-1:1];
          state_nxt = CV_ABS;
        end
      end
      CV_ABS: begin
        mag_nxt   = neg_r ? (fvtb_pkg::TICK_W'(0) - ticks_r) : ticks_r;
        state_nxt = CV_MUL3;
      end
      CV_MUL3: begin
        mag3_nxt  = {2'b00, mag_r} + {1'b0, mag_r, 1'b0};
        state_nxt = CV_SUB;
      end
      CV_SUB: begin
        quo_nxt   = scaled[fvtb_pkg::QUO_W-1:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = CV_DIV;
      end
      CV_DIV: begin
        rem_nxt = part_ge ? part_diff[fvtb_pkg::RATE_W-1:0] : part[fvtb_pkg::RATE_W-1:0];
        quo_nxt = {quo_r[fvtb_pkg::QUO_W-2:0], part_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == fvtb_pkg::CNT_W'(fvtb_pkg::QUO_W - 1)) begin
          state_nxt = CV_SIGN;
        end
      end
      CV_SIGN: begin
        ms_nxt    = neg_r ? (fvtb_pkg::MS_W'(0) - quo_ext) : quo_ext;
        done_nxt  = 1'b1;
        state_nxt = CV_IDLE;
      end
      default: begin
        state_nxt = CV_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    ticks_r <= ticks_nxt;
    neg_r   <= neg_nxt;
    div_r   <= div_nxt;
    half_r  <= half_nxt;
    mag_r   <= mag_nxt;
    mag3_r  <= mag3_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    ms_r    <= ms_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.ms   = ms_r;

endmodule

FILE: sv/flv_video_tag_header_builder.sv
`timescale 1ns / 1ps
// FLV AVC video tag header builder top level: sequencer, stream state and result register.
// Depends on fvtb_pkg, fvtb_in_if / fvtb_out_if and fvtb_ms_conv.
//
// Usage:
//   in_ch carries one frame descriptor (mode 0) or a close request (mode 1) per transfer.
//   out_ch returns one result per transfer: the 16-byte tag header as two 64-bit halves,
//   the previous-tag-size trailer and a status bit (1 = invalid argument, header zeroed).
//   cfg_we/cfg_wdata write frame_rate (0 acts as 1); write it only while the block is idle.
//   A valid frame runs two tick-to-ms conversions through one shared converter, one after
//   the other, each made of request capture, 3 setup steps, 49 divide steps, a sign step
//   and the handoff. A close or a rejected size skips the converter and goes straight to
//   the result.
//   One item at a time: in_ch.ready is high only while the sequencer is idle, so a new item
//   is taken only once the last has left the sequencer; for valid frames the serial divider sets the pace.
//   The result sits in an output register, so the next item is taken while it waits.
//   If out_ch stalls, a finished result waits in the sequencer until the register frees.
//   Reset (rst_n low, synchronous) sets frame_rate to 30, clears the stream state, sets
//   the last tag time to all ones and empties the output register. A close transfer
//   returns the stream state, but not frame_rate, to its reset values.
module flv_video_tag_header_builder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [fvtb_pkg::RATE_W-1:0] cfg_wdata,
  fvtb_in_if.sink                     in_ch,
  fvtb_out_if.source                  out_ch
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PTS   = 5'b00010,
    S_DTS   = 5'b00100,
    S_CHECK = 5'b01000,
    S_EMIT  = 5'b10000
  } seq_state_t;

  seq_state_t                         state_r, state_nxt;
  logic                               start_r, start_nxt;
  logic [fvtb_pkg::RATE_W-1:0]        frame_rate_r;
  logic [fvtb_pkg::RATE_W-1:0]        rate_eff;

  // Stream state
  logic                               started_r, started_nxt;
  logic [fvtb_pkg::MS_W-1:0]          offset_r, offset_nxt;
  logic signed [fvtb_pkg::MS_W-1:0]   prev_dec_r, prev_dec_nxt;
  logic [31:0]                        prev_tag_r, prev_tag_nxt;

  // Latched item and conversion results
  logic [fvtb_pkg::SIZE_W-1:0]        size_r, size_nxt;
  logic signed [fvtb_pkg::TICK_W-1:0] pts_r, pts_nxt;
  logic signed [fvtb_pkg::TICK_W-1:0] dts_r, dts_nxt;
  logic                               key_r, key_nxt;
  logic signed [fvtb_pkg::MS_W-1:0]   pts_ms_r, pts_ms_nxt;
  logic signed [fvtb_pkg::MS_W-1:0]   dts_ms_r, dts_ms_nxt;

  // Finished result waiting for the output register
  logic [fvtb_pkg::HALF_W-1:0]        res_first_r, res_first_nxt;
  logic [fvtb_pkg::HALF_W-1:0]        res_second_r, res_second_nxt;
  logic [fvtb_pkg::TRAILER_W-1:0]     res_trailer_r, res_trailer_nxt;
  logic                               res_status_r, res_status_nxt;

  // Output register
  logic                               out_valid_r, out_valid_nxt;
  logic [fvtb_pkg::HALF_W-1:0]        out_first_r, out_first_nxt;
  logic [fvtb_pkg::HALF_W-1:0]        out_second_r, out_second_nxt;
  logic [fvtb_pkg::TRAILER_W-1:0]     out_trailer_r, out_trailer_nxt;
  logic                               out_status_r, out_status_nxt;

  fvtb_pkg::conv_req_t                conv_req;
  fvtb_pkg::conv_rsp_t                conv_rsp;

  logic                               in_xfer;
  logic                               out_free;
  logic                               size_bad;
  logic                               set_offset;
  logic                               order_err;
  logic [31:0]                        tag_time;
  logic [23:0]                        comp_time;
  logic [3:0]                         frame_kind;

  assign rate_eff = (frame_rate_r == '0) ? fvtb_pkg::RATE_W'(1) : frame_rate_r;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign size_bad = (in_ch.payload_size == '0) || (in_ch.payload_size > fvtb_pkg::MAX_PAYLOAD);

  // Shared converter: pts first, then dts
  assign conv_req.start = start_r;
  assign conv_req.ticks = (state_r == S_DTS) ? dts_r : pts_r;
  assign conv_req.rate  = rate_eff;

  fvtb_ms_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (conv_req),
    .rsp   (conv_rsp)
  );

  // Order checks and tag fields; a fresh offset cancels dts, giving tag time zero
  assign set_offset = !started_r && dts_ms_r[fvtb_pkg::MS_W-1];
  assign order_err  = (started_r && (dts_ms_r < prev_dec_r)) || (pts_ms_r < dts_ms_r);
  assign tag_time   = set_offset ? 32'd0 : (dts_ms_r[31:0] + offset_r[31:0]);
  assign comp_time  = pts_ms_r[23:0] - dts_ms_r[23:0];
  assign frame_kind = key_r ? fvtb_pkg::KEY_FRAME_CODE : fvtb_pkg::INTER_FRAME_CODE;

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    start_nxt       = 1'b0;
    started_nxt     = started_r;
    offset_nxt      = offset_r;
    prev_dec_nxt    = prev_dec_r;
    prev_tag_nxt    = prev_tag_r;
    size_nxt        = size_r;
    pts_nxt         = pts_r;
    dts_nxt         = dts_r;
    key_nxt         = key_r;
    pts_ms_nxt      = pts_ms_r;
    dts_ms_nxt      = dts_ms_r;
    res_first_nxt   = res_first_r;
    res_second_nxt  = res_second_r;
    res_trailer_nxt = res_trailer_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_first_nxt   = out_first_r;
    out_second_nxt  = out_second_r;
    out_trailer_nxt = out_trailer_r;
    out_status_nxt  = out_status_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          size_nxt = in_ch.payload_size;
          pts_nxt  = in_ch.present_time;
          dts_nxt  = in_ch.decode_time;
          key_nxt  = in_ch.is_keyframe;
          if (in_ch.mode) begin
            // End-of-sequence tag at the last tag time, then clear the stream
            res_first_nxt   = {fvtb_pkg::VID_TAG_TYPE, fvtb_pkg::DATA_HDR_LEN,
                               prev_tag_r[23:0], 1'b0, prev_tag_r[30:24]};
            res_second_nxt  = {24'd0, fvtb_pkg::KEY_FRAME_CODE, fvtb_pkg::CODEC_AVC,
                               fvtb_pkg::PKT_END_SEQ, 24'd0};
            res_trailer_nxt = fvtb_pkg::TAG_HDR_LEN;
            res_status_nxt  = 1'b0;
            started_nxt     = 1'b0;
            offset_nxt      = '0;
            prev_dec_nxt    = '0;
            prev_tag_nxt    = '1;
            state_nxt       = S_EMIT;
          end else if (size_bad) begin
            res_first_nxt   = '0;
            res_second_nxt  = '0;
            res_trailer_nxt = '0;
            res_status_nxt  = 1'b1;
            state_nxt       = S_EMIT;
          end else begin
            start_nxt = 1'b1;
            state_nxt = S_PTS;
          end
        end
      end
      S_PTS: begin
        if (conv_rsp.done) begin
          pts_ms_nxt = conv_rsp.ms;
          start_nxt  = 1'b1;
          state_nxt  = S_DTS;
        end
      end
      S_DTS: begin
        if (conv_rsp.done) begin
          dts_ms_nxt = conv_rsp.ms;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        // Offset sticks even when the frame is then rejected
        if (set_offset) begin
          offset_nxt = fvtb_pkg::MS_W'(0) - dts_ms_r;
        end
        if (order_err) begin
          res_first_nxt   = '0;
          res_second_nxt  = '0;
          res_trailer_nxt = '0;
          res_status_nxt  = 1'b1;
        end else begin
          res_first_nxt   = {fvtb_pkg::VID_TAG_TYPE, size_r + fvtb_pkg::DATA_HDR_LEN,
                             tag_time[23:0], 1'b0, tag_time[30:24]};
          res_second_nxt  = {24'd0, frame_kind, fvtb_pkg::CODEC_AVC,
                             fvtb_pkg::PKT_NALU, comp_time};
          res_trailer_nxt = {1'b0, size_r} + fvtb_pkg::TAG_HDR_LEN;
          res_status_nxt  = 1'b0;
          started_nxt     = 1'b1;
          prev_dec_nxt    = dts_ms_r;
          prev_tag_nxt    = tag_time;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // Hold the result until the output register frees
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_first_nxt   = res_first_r;
          out_second_nxt  = res_second_r;
          out_trailer_nxt = res_trailer_r;
          out_status_nxt  = res_status_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      start_r      <= 1'b0;
      frame_rate_r <= fvtb_pkg::RATE_RESET;
      started_r    <= 1'b0;
      offset_r     <= '0;
      prev_dec_r   <= '0;
      prev_tag_r   <= '1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      started_r   <= started_nxt;
      offset_r    <= offset_nxt;
      prev_dec_r  <= prev_dec_nxt;
      prev_tag_r  <= prev_tag_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        frame_rate_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    size_r        <= size_nxt;
    pts_r         <= pts_nxt;
    dts_r         <= dts_nxt;
    key_r         <= key_nxt;
    pts_ms_r      <= pts_ms_nxt;
    dts_ms_r      <= dts_ms_nxt;
    res_first_r   <= res_first_nxt;
    res_second_r  <= res_second_nxt;
    res_trailer_r <= res_trailer_nxt;
    res_status_r  <= res_status_nxt;
    out_first_r   <= out_first_nxt;
    out_second_r  <= out_second_nxt;
    out_trailer_r <= out_trailer_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign in_ch.ready               = (state_r == S_IDLE);
  assign out_ch.valid              = out_valid_r;
  assign out_ch.header_first_half  = out_first_r;
  assign out_ch.header_second_half = out_second_r;
  assign out_ch.trailer_size       = out_trailer_r;
  assign out_ch.status             = out_status_r;

  // Converter is kicked only while the sequencer waits on it
  a_start_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> (state_r == S_PTS || state_r == S_DTS))
    else $error("converter started outside a conversion state");

  // Converter answers only while the sequencer waits on it
  a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    conv_rsp.done |-> (state_r == S_PTS || state_r == S_DTS))
    else $error("converter done outside a conversion state");

  // An accepted item always takes the sequencer out of idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after an input transfer");

  // A rejected item carries a zeroed header and trailer
  a_error_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |->
      (out_first_r == '0 && out_second_r == '0 && out_trailer_r == '0))
    else $error("error result with nonzero header");

  // An accepted frame or close always carries at least the header length
  a_ok_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_status_r) |-> (out_trailer_r >= fvtb_pkg::TAG_HDR_LEN))
    else $error("good result with short trailer size");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for flv_video_tag_header_builder: directed table, then random streams.
// Depends on fvtb_pkg, fvtb_in_if / fvtb_out_if and the RTL of the tag header builder.
module tb_top;
  import fvtb_pkg::*;

  localparam logic MODE_FRAME     = 1'b0;
  localparam logic MODE_CLOSE     = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  localparam logic signed [TICK_W-1:0] TICK_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [TICK_W-1:0] TICK_MIN = 40'sh80_0000_0000;

  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int HOLD_AT         = 500;
  localparam int HOLD_CYCLES     = 2000;
  localparam int DRAIN_CYCLES    = 200;
  localparam int CYCLE_LIMIT     = 1500000;

  typedef struct {
    logic                     mode;
    logic [SIZE_W-1:0]        size;
    logic signed [TICK_W-1:0] pts;
    logic signed [TICK_W-1:0] dts;
    logic                     key;
  } frame_desc_t;

  typedef struct {
    logic [HALF_W-1:0]    first;
    logic [HALF_W-1:0]    second;
    logic [TRAILER_W-1:0] trailer;
    logic                 status;
  } tag_result_t;

  typedef struct {
    logic [RATE_W-1:0] rate;
    frame_desc_t       desc;
    bit                typed;
    tag_result_t       want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [RATE_W-1:0] cfg_wdata;

  fvtb_in_if  in_ch ();
  fvtb_out_if out_ch ();

  flv_video_tag_header_builder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Mirror of the block's register and stream state
  logic [RATE_W-1:0]   rate_reg;
  bit                  stream_live;
  logic signed [63:0]  ts_shift_ms;
  logic signed [63:0]  last_dec_ms;
  logic [31:0]         last_tag_time;
  logic signed [63:0]  last_dts_ticks;

  tag_result_t pending_tags[$];
  stim_row_t   dir_rows[$];

  bit quiet;
  int mismatches;
  int tags_checked;
  int descs_sent;
  int closes_sent;
  int rejects_sent;
  int cycles;

  always #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tags still pending", cycles, pending_tags.size());
      $display("flv_video_tag_header_builder regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 40)
      $display("[%0t] MISMATCH %s: got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Round half away from zero: sign(t) * ((|t| * 1000 + rate / 2) / rate)
  function automatic logic signed [63:0] ticks_to_msec(input logic signed [TICK_W-1:0] t);
    logic signed [63:0] st;
    logic [63:0]        mag;
    logic [63:0]        div;
    logic [63:0]        q;
    st  = t;
    div = (rate_reg == '0) ? 64'd1 : {54'd0, rate_reg};
    mag = st[63] ? -st : st;
    q   = (mag * 64'd1000 + div / 2) / div;
    return st[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic tag_result_t predict_tag(input frame_desc_t d);
    tag_result_t        r;
    logic signed [63:0] pts_ms;
    logic signed [63:0] dts_ms;
    logic signed [63:0] comp_ms;
    logic signed [63:0] tag_ms;
    r.first   = '0;
    r.second  = '0;
    r.trailer = '0;
    r.status  = STATUS_OK;

    // Close: end-of-sequence tag at the last tag time, then clear the stream
    if (d.mode == MODE_CLOSE) begin
      r.first   = {VID_TAG_TYPE, DATA_HDR_LEN, last_tag_time[23:0], 1'b0,
                   last_tag_time[30:24]};
      r.second  = {24'd0, KEY_FRAME_CODE, CODEC_AVC, PKT_END_SEQ, 24'd0};
      r.trailer = TAG_HDR_LEN;
      stream_live   = 1'b0;
      ts_shift_ms   = '0;
      last_dec_ms   = '0;
      last_tag_time = '1;
      return r;
    end

    if (d.size == '0 || d.size > MAX_PAYLOAD) begin
      r.status = STATUS_INVALID;
      return r;
    end

    pts_ms = ticks_to_msec(d.pts);
    dts_ms = ticks_to_msec(d.dts);
    // Offset sticks even when the frame is then rejected
    if (!stream_live && dts_ms < 0)
      ts_shift_ms = -dts_ms;
    if ((stream_live && dts_ms < last_dec_ms) || pts_ms < dts_ms) begin
      r.status = STATUS_INVALID;
      return r;
    end

    stream_live   = 1'b1;
    last_dec_ms   = dts_ms;
    tag_ms        = dts_ms + ts_shift_ms;
    last_tag_time = tag_ms[31:0];
    comp_ms       = pts_ms - dts_ms;
    r.first   = {VID_TAG_TYPE, d.size + DATA_HDR_LEN, tag_ms[23:0], 1'b0, tag_ms[30:24]};
    r.second  = {24'd0, (d.key ? KEY_FRAME_CODE : INTER_FRAME_CODE), CODEC_AVC, PKT_NALU,
                 comp_ms[23:0]};
    r.trailer = {1'b0, d.size} + TAG_HDR_LEN;
    return r;
  endfunction

  // Offer one descriptor, wait for the transfer, then queue its expected tag
  task automatic send_descriptor(input frame_desc_t d, input bit typed, input tag_result_t want);
    int          gap;
    tag_result_t res;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.mode         = d.mode;
    in_ch.payload_size = d.size;
    in_ch.present_time = d.pts;
    in_ch.decode_time  = d.dts;
    in_ch.is_keyframe  = d.key;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (!in_ch.ready);

    res = predict_tag(d);
    if (d.mode == MODE_CLOSE)
      closes_sent++;
    else if (res.status == STATUS_INVALID)
      rejects_sent++;
    else
      last_dts_ticks = d.dts;
    pending_tags.push_back(typed ? want : res);
    descs_sent++;
  endtask

  // Drop valid and wait until every queued tag has come back
  task automatic drain;
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
  endtask

  task automatic set_frame_rate(input logic [RATE_W-1:0] rate);
    drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = rate;
    @(negedge clk);
    cfg_we    = 1'b0;
    rate_reg  = rate;
  endtask

  function automatic void add_row(input logic [RATE_W-1:0] rate, input logic mode,
                                  input logic [SIZE_W-1:0] size,
                                  input logic signed [TICK_W-1:0] pts,
                                  input logic signed [TICK_W-1:0] dts, input logic key);
    stim_row_t row;
    row.rate          = rate;
    row.desc.mode     = mode;
    row.desc.size     = size;
    row.desc.pts      = pts;
    row.desc.dts      = dts;
    row.desc.key      = key;
    row.typed         = 1'b0;
    row.want.first    = '0;
    row.want.second   = '0;
    row.want.trailer  = '0;
    row.want.status   = STATUS_OK;
    dir_rows.push_back(row);
  endfunction

  // Pin the expected tag of the last row
  function automatic void want_last(input logic [HALF_W-1:0] first,
                                    input logic [HALF_W-1:0] second,
                                    input logic [TRAILER_W-1:0] trailer, input logic status);
    int n;
    n = dir_rows.size() - 1;
    dir_rows[n].typed        = 1'b1;
    dir_rows[n].want.first   = first;
    dir_rows[n].want.second  = second;
    dir_rows[n].want.trailer = trailer;
    dir_rows[n].want.status  = status;
  endfunction

  // Mostly well-formed streams with random content, plus closes, noise and broken frames
  function automatic frame_desc_t next_descriptor();
    frame_desc_t        d;
    int                 pick;
    logic signed [63:0] base;
    logic signed [63:0] step;
    logic [63:0]        r64;
    pick   = $urandom_range(0, 99);
    d.mode = MODE_FRAME;
    d.key  = $urandom_range(0, 1);
    d.size = ($urandom_range(0, 19) == 0) ? $urandom_range(16777000, 16777210)
                                           : $urandom_range(1, 4000);
    if (stream_live && last_dts_ticks > 64'sd549000000000)
      pick = 0;
    if (!stream_live) begin
      case ($urandom_range(0, 3))
        0:       base = -$signed({32'd0, $urandom_range(0, 300)});
        1:       base = $signed({$urandom, $urandom} >> 26);
        default: base = $signed({32'd0, $urandom_range(0, 300)});
      endcase
    end else begin
      base = last_dts_ticks + $signed({32'd0, $urandom_range(0, 6)});
    end
    step = ($urandom_range(0, 9) == 0) ? $signed({32'd0, $urandom_range(0, 1 << 22)})
                                       : $signed({32'd0, $urandom_range(0, 4)});
    d.dts = base[TICK_W-1:0];
    d.pts = base[TICK_W-1:0] + step[TICK_W-1:0];

    if (pick < 4) begin
      // Close with junk in the ignored fields
      d.mode = MODE_CLOSE;
      d.size = $urandom;
      r64    = {$urandom, $urandom};
      d.pts  = r64[39:0];
      r64    = {$urandom, $urandom};
      d.dts  = r64[39:0];
    end else if (pick < 12) begin
      d.size = $urandom;
      r64    = {$urandom, $urandom};
      d.pts  = r64[39:0];
      r64    = {$urandom, $urandom};
      d.dts  = r64[39:0];
    end else if (pick < 16) begin
      d.size = $urandom_range(0, 1) ? '0 : $urandom_range(16777211, 16777215);
    end else if (pick < 20) begin
      if (stream_live && $urandom_range(0, 1)) begin
        base  = last_dts_ticks - $signed({32'd0, $urandom_range(30, 3000)});
        d.dts = base[TICK_W-1:0];
        d.pts = d.dts;
      end else begin
        d.pts = d.dts - $urandom_range(1, 3000);
      end
    end
    return d;
  endfunction

  // Result side: draw a stall per tag, with one long hold to back up the input
  initial begin : tag_receiver
    int stall;
    bit hold_done;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 19);
      if (!hold_done && tags_checked >= HOLD_AT) begin
        hold_done = 1'b1;
        stall     = HOLD_CYCLES;
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compare each transfer with the oldest pending tag
  always @(posedge clk) begin : tag_checker
    tag_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_tags.size() == 0) begin
        report_mismatch("tag with nothing pending", out_ch.header_first_half, '0);
      end else begin
        want = pending_tags.pop_front();
        if (out_ch.header_first_half !== want.first)
          report_mismatch("header_first_half", out_ch.header_first_half, want.first);
        if (out_ch.header_second_half !== want.second)
          report_mismatch("header_second_half", out_ch.header_second_half, want.second);
        if (out_ch.trailer_size !== want.trailer)
          report_mismatch("trailer_size", out_ch.trailer_size, want.trailer);
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
      end
      tags_checked++;
    end
  end

  initial begin : stimulus
    logic [RATE_W-1:0] phase_rates[NUM_PHASES];
    tag_result_t       none;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_FRAME;
    in_ch.payload_size = '0;
    in_ch.present_time = '0;
    in_ch.decode_time  = '0;
    in_ch.is_keyframe  = 1'b0;
    quiet              = 1'b0;
    none.first         = '0;
    none.second        = '0;
    none.trailer       = '0;
    none.status        = STATUS_OK;

    rate_reg       = RATE_RESET;
    stream_live    = 1'b0;
    ts_shift_ms    = '0;
    last_dec_ms    = '0;
    last_tag_time  = '1;
    last_dts_ticks = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table: close before any frame, size limits, negative first decode time,
    // order errors, rounding halves, composition wrap, tick extremes, rate extremes
    add_row(30, MODE_CLOSE, 0, 0, 0, 0);
    want_last(64'h0900_0005_FFFF_FF7F, 64'h0000_0017_0200_0000, 25'd16, STATUS_OK);
    add_row(30, MODE_FRAME, 0, 10, 10, 1);
    want_last('0, '0, '0, STATUS_INVALID);
    add_row(30, MODE_FRAME, 24'd16777211, 10, 10, 1);
    want_last('0, '0, '0, STATUS_INVALID);
    add_row(30, MODE_FRAME, 24'hFF_FFFF, 10, 10, 0);
    want_last('0, '0, '0, STATUS_INVALID);
    add_row(30, MODE_FRAME, 100, -120, -90, 1);
    add_row(30, MODE_FRAME, 1, -30, -60, 1);
    add_row(30, MODE_FRAME, MAX_PAYLOAD, 0, 0, 0);
    add_row(30, MODE_FRAME, 500, 0, -30, 0);
    add_row(30, MODE_FRAME, 500, 1, 1, 1);
    add_row(30, MODE_FRAME, 500, 600000, 2, 0);
    add_row(30, MODE_CLOSE, 0, 0, 0, 0);
    add_row(16, MODE_FRAME, 7, 1, -1, 1);
    add_row(16, MODE_FRAME, 7, 1, 1, 0);
    add_row(16, MODE_CLOSE, 0, 0, 0, 0);
    add_row(1, MODE_FRAME, 1, TICK_MAX, TICK_MAX, 1);
    add_row(1, MODE_FRAME, 1, TICK_MAX, TICK_MIN, 0);
    add_row(1, MODE_CLOSE, 0, 0, 0, 0);
    add_row(1, MODE_FRAME, 2, TICK_MAX, TICK_MIN, 1);
    add_row(1, MODE_CLOSE, 0, 0, 0, 0);
    add_row(0, MODE_FRAME, 3, 7, 5, 0);
    add_row(1023, MODE_FRAME, 4, 1535, 1534, 1);
    add_row(1000, MODE_FRAME, 5, 12346, 12345, 0);
    add_row(1000, MODE_CLOSE, 24'hFF_FFFF, -1, -1, 1);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].rate != rate_reg)
        set_frame_rate(dir_rows[i].rate);
      send_descriptor(dir_rows[i].desc, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random streams over a sweep of frame rates, every third phase without idling
    phase_rates = '{10'd30, 10'd1, 10'd1000, 10'd0, 10'd1023, 10'd16, 10'd25, 10'd60,
                    10'd0, 10'd0};
    phase_rates[8] = $urandom_range(1, 1000);
    phase_rates[9] = $urandom_range(0, 1023);
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_frame_rate(phase_rates[p]);
      quiet = (p % 3 == 2);
      repeat (ITEMS_PER_PHASE) send_descriptor(next_descriptor(), 1'b0, none);
    end

    drain();
    quiet = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d descriptors (%0d closes, %0d rejected frames): %0d table rows, %0d phases.",
             descs_sent, closes_sent, rejects_sent, dir_rows.size(), NUM_PHASES);
    $display("Checked %0d tags field by field, %0d mismatches, %0d cycles.",
             tags_checked, mismatches, cycles);
    if (mismatches == 0 && pending_tags.size() == 0)
      $display("flv_video_tag_header_builder regression: pass");
    else
      $display("flv_video_tag_header_builder regression: fail");
    $finish;
  end

endmodule
